// File: rtl/priority_work_stealing_deque_top_defines.svh
// assertion macros shared by the deque set
`ifndef PRIORITY_WORK_STEALING_DEQUE_TOP_DEFINES_SVH
`define PRIORITY_WORK_STEALING_DEQUE_TOP_DEFINES_SVH

// checked only while out of reset, on i_clk with i_rst_n
`define PWSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge of i_clk, reset included
`define PWSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/pwsd_pkg.sv
`timescale 1ns / 1ps

package pwsd_pkg;

    // command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP_NEW = 2'd1;
    localparam logic [1:0] CMD_POP_OLD = 2'd2;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int PRIO_W  = 3;
    localparam int WORD_W  = 64;
    localparam int LVOUT_W = 3;

    // status of one result word
    typedef struct packed {
        logic               found;
        logic               rejected;
        logic [LVOUT_W-1:0] level;
    } t_res_meta;

endpackage

// File: rtl/pwsd_store.sv
`timescale 1ns / 1ps

module pwsd_store import pwsd_pkg::*; #(
    parameter int ENTRIES    = 2048,
    parameter int ITEM_WIDTH = 64,
    parameter int AW         = 11
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_addr,
    input  logic [ITEM_WIDTH-1:0] i_wdata,
    output logic [ITEM_WIDTH-1:0] o_rdata
);

    logic [ITEM_WIDTH-1:0] r_mem [ENTRIES];
    logic [ITEM_WIDTH-1:0] r_rdata;

    // single port entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pwsd_ptr_ctrl.sv
`timescale 1ns / 1ps

module pwsd_ptr_ctrl import pwsd_pkg::*; #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 256,
    parameter int AW     = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [PRIO_W-1:0] i_priority_req,
    output logic              o_mem_we,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_addr,
    output t_res_meta         o_meta
);

    localparam int LW       = $clog2(LEVELS);
    localparam int PW       = $clog2(2 * DEPTH);
    localparam int SW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_LAST = 2 * DEPTH - 1;

    logic [PW-1:0] r_top [LEVELS];
    logic [PW-1:0] r_bot [LEVELS];

    logic [LEVELS-1:0] nonempty;
    logic              any_ready;
    logic [LW-1:0]     pop_lv;
    logic [LW-1:0]     push_lv;
    logic [PW-1:0]     push_bot;
    logic [PW-1:0]     push_top;
    logic [PW:0]       push_diff;
    logic [PW:0]       push_cnt;
    logic              push_full;
    logic [PW-1:0]     pop_bot_dec;
    logic [PW-1:0]     pop_top;
    logic [PW-1:0]     pop_top_inc;
    logic [PW-1:0]     push_bot_inc;
    logic [PW-1:0]     sel_ptr;
    logic [LW-1:0]     sel_lv;
    logic [SW-1:0]     sel_slot;
    logic [6:0]        pop_lv_ext;

    // non-empty flags and lowest-numbered ready level
    always_comb begin
        any_ready = 1'b0;
        pop_lv    = '0;
        for (int l = 0; l < LEVELS; l++) begin
            nonempty[l] = (r_bot[l] != r_top[l]);
        end
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (nonempty[l]) begin
                pop_lv    = LW'(l);
                any_ready = 1'b1;
            end
        end
    end

    // push level with saturation and fill check
    always_comb begin
        if (7'(i_priority_req) > 7'(LEVELS - 1)) begin
            push_lv = LW'(LEVELS - 1);
        end else begin
            push_lv = LW'(i_priority_req);
        end
        push_bot  = r_bot[push_lv];
        push_top  = r_top[push_lv];
        push_diff = {1'b0, push_bot} - {1'b0, push_top};
        push_cnt  = (push_bot >= push_top) ? push_diff
                                           : push_diff + (PW+1)'(2 * DEPTH);
        push_full = (push_cnt == (PW+1)'(DEPTH));
    end

    // pointer steps modulo twice the depth
    always_comb begin
        pop_bot_dec  = (r_bot[pop_lv] == '0) ? PW'(PTR_LAST) : r_bot[pop_lv] - 1'b1;
        pop_top      = r_top[pop_lv];
        pop_top_inc  = (pop_top == PW'(PTR_LAST)) ? '0 : pop_top + 1'b1;
        push_bot_inc = (push_bot == PW'(PTR_LAST)) ? '0 : push_bot + 1'b1;
    end

    // operation decode and entry address
    always_comb begin
        o_mem_we        = 1'b0;
        o_mem_re        = 1'b0;
        sel_ptr         = push_bot;
        sel_lv          = push_lv;
        pop_lv_ext      = 7'(pop_lv);
        o_meta.found    = 1'b0;
        o_meta.rejected = 1'b0;
        o_meta.level    = '0;
        case (i_cmd)
            CMD_PUSH: begin
                o_meta.rejected = push_full;
                o_mem_we        = i_go && !push_full;
            end
            CMD_POP_NEW: begin
                sel_ptr      = pop_bot_dec;
                sel_lv       = pop_lv;
                o_mem_re     = i_go && any_ready;
                o_meta.found = any_ready;
                o_meta.level = any_ready ? pop_lv_ext[LVOUT_W-1:0] : '0;
            end
            CMD_POP_OLD: begin
                sel_ptr      = pop_top;
                sel_lv       = pop_lv;
                o_mem_re     = i_go && any_ready;
                o_meta.found = any_ready;
                o_meta.level = any_ready ? pop_lv_ext[LVOUT_W-1:0] : '0;
            end
            default: begin
            end
        endcase
        sel_slot   = (sel_ptr >= PW'(DEPTH)) ? SW'(sel_ptr - PW'(DEPTH)) : SW'(sel_ptr);
        o_mem_addr = AW'(AW'(sel_lv) * AW'(DEPTH)) + AW'(sel_slot);
    end

    // pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_top[l] <= '0;
                r_bot[l] <= '0;
            end
        end else if (i_go) begin
            case (i_cmd)
                CMD_PUSH: begin
                    if (!push_full) begin
                        r_bot[push_lv] <= push_bot_inc;
                    end
                end
                CMD_POP_NEW: begin
                    if (any_ready) begin
                        r_bot[pop_lv] <= pop_bot_dec;
                    end
                end
                CMD_POP_OLD: begin
                    if (any_ready) begin
                        r_top[pop_lv] <= pop_top_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/priority_work_stealing_deque_top.sv
`timescale 1ns / 1ps
// Set of LEVELS task deques, one per priority level, each a ring of DEPTH words held in one
// single-port synchronous memory; the head and tail pointers of every level sit in flops.
// A push (cmd 0) appends at the tail of its level (priority above LEVELS-1 saturates) and a
// full level answers rejected; cmd 1 pops the newest and cmd 2 the oldest word of the
// lowest-numbered non-empty level, with found and the level number in the result. One word
// is taken per clock cycle while o_in_stall is low. The edge that takes a word updates the
// pointers and starts the registered memory read; stage one holds the status beside it until
// the output register is free, which then loads status and read word. The output register
// lets the next word in while a result waits. No memory clearing pass after reset.

`include "priority_work_stealing_deque_top_defines.svh"

module priority_work_stealing_deque_top import pwsd_pkg::*; #(
    parameter int LEVELS     = 8,
    parameter int DEPTH      = 256,
    parameter int ITEM_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PRIO_W-1:0]  i_priority_req,
    input  logic [WORD_W-1:0]  i_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_item_out,
    output logic               o_found,
    output logic               o_rejected,
    output logic [LVOUT_W-1:0] o_level_out
);

    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    logic                  go;
    logic                  out_free;
    logic                  s1_move;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [ITEM_WIDTH-1:0] mem_rdata;
    t_res_meta             meta;

    logic                  r_s1_valid;
    t_res_meta             r_s1_meta;
    logic                  r_out_valid;
    t_res_meta             r_out_meta;
    logic [WORD_W-1:0]     r_out_item;

    // handshake: a word moves in when stage one is empty or drains into the output
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign go         = i_in_valid && !o_in_stall;

    pwsd_ptr_ctrl #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_ptr_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_cmd          (i_cmd),
        .i_priority_req (i_priority_req),
        .o_mem_we       (mem_we),
        .o_mem_re       (mem_re),
        .o_mem_addr     (mem_addr),
        .o_meta         (meta)
    );

    pwsd_store #(
        .ENTRIES    (ENTRIES),
        .ITEM_WIDTH (ITEM_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_item[ITEM_WIDTH-1:0]),
        .o_rdata (mem_rdata)
    );

    // stage one: status waits beside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_meta <= meta;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_meta <= r_s1_meta;
            r_out_item <= r_s1_meta.found ? WORD_W'(mem_rdata) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item_out  = r_out_item;
    assign o_found     = r_out_meta.found;
    assign o_rejected  = r_out_meta.rejected;
    assign o_level_out = r_out_meta.level;

    // checks
    `PWSD_ASSERT(a_found_rejected_excl, o_out_valid |-> !(o_found && o_rejected), "both set")
    `PWSD_ASSERT(a_miss_word_zero, o_out_valid && !o_found |-> o_item_out == '0, "stray word")
    `PWSD_ASSERT(a_no_overrun, r_s1_valid && r_out_valid && i_out_stall |-> o_in_stall, "overrun")
    `PWSD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid && !r_s1_valid, "valid set")

endmodule

// File: sim/pwsd_checker.sv
`timescale 1ns / 1ps

// watches both channels of the deque set, predicts each result word and compares it
module pwsd_checker import pwsd_pkg::*; #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PRIO_W-1:0]  i_priority_req,
    input  logic [WORD_W-1:0]  i_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [WORD_W-1:0]  i_item_out,
    input  logic               i_found,
    input  logic               i_rejected,
    input  logic [LVOUT_W-1:0] i_level_out,
    output int                 o_mismatches,
    output int                 o_waiting,
    output int                 o_full_rejects,
    output int                 o_pops_found
);

    // pointers run modulo twice the ring size so a full ring differs from an empty one
    localparam int PTR_W  = $clog2(2 * DEPTH);
    localparam int SLOT_W = PTR_W - 1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_res_meta         meta;
    } t_outcome;

    // private copy of the rings: own_ptr is the bottom, steal_ptr the top
    logic [WORD_W-1:0] ring_words [LEVELS][DEPTH];
    logic [PTR_W-1:0]  own_ptr    [LEVELS];
    logic [PTR_W-1:0]  steal_ptr  [LEVELS];
    t_outcome          awaited_results [$];

    int mismatches   = 0;
    int full_rejects = 0;
    int pops_found   = 0;

    assign o_mismatches   = mismatches;
    assign o_full_rejects = full_rejects;
    assign o_pops_found   = pops_found;

    // applies one command word to the rings and returns the result it must give
    function automatic t_outcome apply_command(input logic [CMD_W-1:0]  cmd,
                                               input logic [PRIO_W-1:0] prio,
                                               input logic [WORD_W-1:0] word);
        t_outcome         res;
        int               lv;
        int               pick;
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] fill;
        res  = '0;
        pick = -1;
        if (cmd == CMD_PUSH) begin
            // priority beyond the last level saturates
            lv   = (prio > LEVELS - 1) ? LEVELS - 1 : int'(prio);
            fill = own_ptr[lv] - steal_ptr[lv];
            if (fill >= DEPTH) begin
                res.meta.rejected = 1'b1;
            end else begin
                p = own_ptr[lv];
                ring_words[lv][p[SLOT_W-1:0]] = word;
                own_ptr[lv] = p + 1'b1;
            end
        end else if (cmd == CMD_POP_NEW || cmd == CMD_POP_OLD) begin
            // lowest-numbered level that holds anything
            for (lv = LEVELS - 1; lv >= 0; lv--) begin
                if (own_ptr[lv] != steal_ptr[lv])
                    pick = lv;
            end
            if (pick >= 0) begin
                if (cmd == CMD_POP_NEW) begin
                    p = own_ptr[pick] - 1'b1;
                    own_ptr[pick] = p;
                end else begin
                    p = steal_ptr[pick];
                    steal_ptr[pick] = p + 1'b1;
                end
                res.word       = ring_words[pick][p[SLOT_W-1:0]];
                res.meta.found = 1'b1;
                res.meta.level = LVOUT_W'(pick);
            end
        end
        return res;
    endfunction

    // compare each accepted result word, then predict each accepted command word
    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                own_ptr[l]   = '0;
                steal_ptr[l] = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.word          = i_item_out;
                got.meta.found    = i_found;
                got.meta.rejected = i_rejected;
                got.meta.level    = i_level_out;
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing expected: item_out %h", got.word);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.word !== want.word) begin
                        $error("item_out: expected %h, got %h", want.word, got.word);
                        mismatches++;
                    end
                    if (got.meta.found !== want.meta.found) begin
                        $error("found: expected %b, got %b", want.meta.found, got.meta.found);
                        mismatches++;
                    end
                    if (got.meta.rejected !== want.meta.rejected) begin
                        $error("rejected: expected %b, got %b",
                               want.meta.rejected, got.meta.rejected);
                        mismatches++;
                    end
                    if (got.meta.level !== want.meta.level) begin
                        $error("level_out: expected %0d, got %0d",
                               want.meta.level, got.meta.level);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_command(i_cmd, i_priority_req, i_item);
                if (want.meta.rejected)
                    full_rejects++;
                if (want.meta.found)
                    pops_found++;
                awaited_results.push_back(want);
            end
        end
        o_waiting = awaited_results.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pwsd_pkg::*;

    localparam int                 LIMIT       = 200000;
    localparam int                 HOLD_CYCLES = 300;
    localparam int                 FAVORED     = 4;
    localparam logic [CMD_W-1:0]   CMD_NONE    = 2'd3;
    localparam logic [WORD_W-1:0]  ALL_ONES    = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd;
    logic [PRIO_W-1:0]  prio;
    logic [WORD_W-1:0]  item;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [WORD_W-1:0]  item_out;
    logic               found;
    logic               rejected;
    logic [LVOUT_W-1:0] level_out;

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_request;
    int hold_left   = 0;
    logic hold_done = 1'b0;
    int cycle_count = 0;
    int words_sent  = 0;

    int mismatches;
    int waiting;
    int full_rejects;
    int pops_found;

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    priority_work_stealing_deque_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_priority_req (prio),
        .i_item         (item),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_item_out     (item_out),
        .o_found        (found),
        .o_rejected     (rejected),
        .o_level_out    (level_out)
    );

    pwsd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_priority_req (prio),
        .i_item         (item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_item_out     (item_out),
        .i_found        (found),
        .i_rejected     (rejected),
        .i_level_out    (level_out),
        .o_mismatches   (mismatches),
        .o_waiting      (waiting),
        .o_full_rejects (full_rejects),
        .o_pops_found   (pops_found)
    );

    // receiver: random stalls, plus one long hold-off once requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // offer one command word, with random idle cycles ahead of it
    task automatic send_word(input logic [CMD_W-1:0]  c,
                             input logic [PRIO_W-1:0] p,
                             input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        prio     <= p;
        item     <= w;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        words_sent++;
    endtask

    function automatic logic [WORD_W-1:0] random_task();
        return {$urandom, $urandom};
    endfunction

    // general traffic: pushes lean towards one level, pops of both kinds, some unused codes
    task automatic send_mixed(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 50)
                send_word(CMD_PUSH, $urandom_range(1) ? PRIO_W'(FAVORED)
                                                      : PRIO_W'($urandom_range(7)),
                          random_task());
            else if (r < 72)
                send_word(CMD_POP_NEW, PRIO_W'($urandom_range(7)), random_task());
            else if (r < 94)
                send_word(CMD_POP_OLD, PRIO_W'($urandom_range(7)), random_task());
            else
                send_word(CMD_NONE, PRIO_W'($urandom_range(7)), random_task());
        end
    endtask

    // push a run of words to one level, past the point where it is full
    task automatic fill_level(input int lv, input int count);
        for (int n = 0; n < count; n++)
            send_word(CMD_PUSH, PRIO_W'(lv), random_task());
    endtask

    // mostly pops, with a few pushes and unused codes mixed in
    task automatic drain_mixed(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 45)
                send_word(CMD_POP_NEW, PRIO_W'($urandom_range(7)), random_task());
            else if (r < 88)
                send_word(CMD_POP_OLD, PRIO_W'($urandom_range(7)), random_task());
            else if (r < 96)
                send_word(CMD_PUSH, PRIO_W'($urandom_range(7)), random_task());
            else
                send_word(CMD_NONE, PRIO_W'($urandom_range(7)), random_task());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_PUSH;
        prio          <= '0;
        item          <= '0;
        hold_request  <= 1'b0;
        recv_idle_pct <= 52;
        send_idle_pct = 25;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pops on an empty set and the unused code
        send_word(CMD_POP_NEW, 3'd0, ALL_ONES);
        send_word(CMD_POP_OLD, 3'd7, ALL_ONES);
        send_word(CMD_NONE, 3'd0, '0);
        // extremes of level and word
        send_word(CMD_PUSH, 3'd7, ALL_ONES);
        send_word(CMD_PUSH, 3'd0, '0);
        send_word(CMD_PUSH, 3'd0, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(CMD_PUSH, 3'd5, 64'h5555_5555_5555_5555);
        // lowest level goes first, newest from the bottom and oldest from the top
        send_word(CMD_POP_NEW, 3'd7, '0);
        send_word(CMD_POP_OLD, 3'd0, '0);
        send_word(CMD_POP_NEW, 3'd0, '0);
        send_word(CMD_POP_OLD, 3'd0, '0);
        send_word(CMD_POP_NEW, 3'd0, '0);
        send_word(CMD_NONE, 3'd7, ALL_ONES);
        // both ends of one level
        send_word(CMD_PUSH, 3'd3, 64'h0000_0000_0000_0001);
        send_word(CMD_PUSH, 3'd3, 64'h8000_0000_0000_0000);
        send_word(CMD_PUSH, 3'd3, 64'h0123_4567_89ab_cdef);
        send_word(CMD_POP_OLD, 3'd0, '0);
        send_word(CMD_POP_NEW, 3'd0, '0);
        send_word(CMD_POP_OLD, 3'd0, '0);
        // a higher level waits behind a lower one
        send_word(CMD_PUSH, 3'd6, 64'hdead_beef_0000_ffff);
        send_word(CMD_PUSH, 3'd1, 64'hffff_0000_beef_dead);
        send_word(CMD_POP_OLD, 3'd0, '0);
        send_word(CMD_POP_OLD, 3'd0, '0);

        send_mixed(200);

        // swap idling; long hold-off at the receiver while a level fills to the brim
        send_idle_pct = 52;
        recv_idle_pct <= 25;
        hold_request  <= 1'b1;
        fill_level(FAVORED, 258);
        drain_mixed(200);

        // no idling; a second fill after partial draining moves that level further round
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        fill_level(FAVORED, 258);
        drain_mixed(230);

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d words: pushes on all levels, %0d pushes to a full level,",
                 words_sent, full_rejects);
        $display("%0d owner and steal pops that found a word, pops on an empty set",
                 pops_found);
        if (mismatches == 0 && waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
